// ===== hdl/soc_pkg.sv =====
package soc_pkg;

	localparam int CW   = 20;
	localparam int RW   = 16;
	localparam int RF   = RW - 2;
	localparam int HW   = CW - 1;
	localparam int RADW = CW - 1;
	localparam int OFFW = CW + 1;
	localparam int PRW  = OFFW + RW;
	localparam int ACW  = PRW + 2;
	localparam int LOCW = ACW - RF;
	localparam int DIFW = LOCW + 1;
	localparam int SQW  = 2 * DIFW;
	localparam int D2W  = SQW + 2;
	localparam int R2W  = 2 * RADW;
	localparam int SQSH = 16;
	localparam int SQIN = R2W + SQSH;
	localparam int RTW  = SQIN / 2;
	localparam int MAGW = RADW;
	localparam int NUMW = MAGW + RF + 10;
	localparam int DENW = RTW + 1;
	localparam int QW   = RF + 3;
	localparam int NLW  = QW + 1;
	localparam int WPW  = RW + NLW;
	localparam int WAW  = WPW + 2;
	localparam int WLW  = WAW - RF;

	typedef struct packed {
		logic [3*CW-1:0] sphere_center;
		logic [RADW-1:0] sphere_radius;
		logic [3*CW-1:0] box_center;
		logic [3*CW-1:0] box_half_extents;
		logic [3*RW-1:0] box_axis_x;
		logic [3*RW-1:0] box_axis_y;
		logic [3*RW-1:0] box_axis_z;
	} query_t;

	typedef struct packed {
		logic            hit;
		logic            center_inside;
		logic [3*RW-1:0] contact_normal;
		logic [CW-1:0]   penetration_depth;
	} contact_t;

	typedef enum logic [1:0] {
		FACE_X,
		FACE_Y,
		FACE_Z
	} face_t;

	typedef struct packed {
		logic [2:0][3*RW-1:0] axis;
		logic                 hit;
		logic                 ctr_in;
		face_t                face;
		logic                 face_pos;
		logic [CW-1:0]        pen;
		logic [RADW-1:0]      rad;
		logic [2:0][MAGW-1:0] mag;
		logic [2:0]           dneg;
	} side_t;

endpackage

// ===== hdl/sphere_obb_contact_core.sv =====
// Sphere versus oriented box contact test, one pair per beat.
// Query channel: query_valid/query_ready carry one sphere (center, radius) and
// one box (center, half extents, three rotation columns) per beat.
// Contact channel: contact_valid/contact_ready return one beat per query with
// hit, center_inside, the world contact normal and the penetration depth.
// Throughput: one query per cycle, sustained while the skid entry is empty.
// Pipeline: the 27-stage square root (one root bit per stage) and the 17-stage
// normal dividers (one quotient bit per stage) make up most of its depth; six
// stages of rotation, clamp and squares come before, and three of normal
// rotation and saturation after.
// Stall: an output register plus one skid entry sit at the end. While the skid
// entry is full the whole pipeline holds and query_ready is low; no beat is
// lost or repeated. query_ready does not depend on contact_ready in the same
// cycle.
// Reset: arst_n clears all valid bits and the output stage; the block is ready
// in the cycle after reset is released.
module sphere_obb_contact_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_ready,
	input  soc_pkg::query_t   query,
	output logic              contact_valid,
	input  logic              contact_ready,
	output soc_pkg::contact_t contact
);
	import soc_pkg::*;

	localparam int SQN = RTW;
	localparam int DVN = QW;
	localparam logic signed [NLW-1:0] ONE  = NLW'(1 << RF);
	localparam logic signed [WLW-1:0] WMAX = WLW'((1 << (RW - 1)) - 1);
	localparam logic signed [WLW-1:0] WMIN = -WMAX - WLW'(1);

	logic en;
	logic live_q;
	logic skid_v_q, out_v_q;
	contact_t out_q, skid_q;

	assign en          = ~skid_v_q;
	assign query_ready = en & live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else begin
			live_q <= 1'b1;
		end
	end

	// stage 1: offsets, clamped half extents
	logic v_s1;
	logic signed [OFFW-1:0] off_c [3];
	logic [HW-1:0]          half_c [3];
	logic signed [OFFW-1:0] off_s1 [3];
	logic [HW-1:0]          half_s1 [3];
	logic [RADW-1:0]        rad_s1;
	logic [2:0][3*RW-1:0]   ax_s1;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			off_c[j] = OFFW'($signed(query.sphere_center[j*CW +: CW]))
			         - OFFW'($signed(query.box_center[j*CW +: CW]));
			half_c[j] = query.box_half_extents[j*CW+CW-1] ? '0
			          : query.box_half_extents[j*CW +: HW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s1  <= off_c;
			half_s1 <= half_c;
			rad_s1  <= query.sphere_radius;
			ax_s1   <= {query.box_axis_z, query.box_axis_y, query.box_axis_x};
		end
	end

	// stage 2: rotation products
	logic v_s2;
	logic signed [PRW-1:0] prod_c [3][3];
	logic signed [PRW-1:0] prod_s2 [3][3];
	logic [HW-1:0]         half_s2 [3];
	logic [RADW-1:0]       rad_s2;
	logic [2:0][3*RW-1:0]  ax_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_c[i][j] = PRW'($signed(ax_s1[i][j*RW +: RW])) * PRW'(off_s1[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_c;
			half_s2 <= half_s1;
			rad_s2  <= rad_s1;
			ax_s2   <= ax_s1;
		end
	end

	// stage 3: local coordinates, round half up
	logic v_s3;
	logic signed [ACW-1:0]  acc_c [3];
	logic signed [ACW-1:0]  accr_c [3];
	logic signed [LOCW-1:0] loc_s3 [3];
	logic [HW-1:0]          half_s3 [3];
	logic [RADW-1:0]        rad_s3;
	logic [2:0][3*RW-1:0]   ax_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = ACW'(prod_s2[i][0]) + ACW'(prod_s2[i][1]) + ACW'(prod_s2[i][2])
			         + ACW'(1 << (RF - 1));
			accr_c[i] = acc_c[i] >>> RF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				loc_s3[i] <= accr_c[i][LOCW-1:0];
			end
			half_s3 <= half_s2;
			rad_s3  <= rad_s2;
			ax_s3   <= ax_s2;
		end
	end

	// stage 4: clamp, offset to clamped point, face distances
	logic v_s4;
	logic signed [LOCW-1:0] hs_c [3];
	logic signed [LOCW-1:0] cl_c [3];
	logic signed [DIFW-1:0] la_c [3];
	logic signed [DIFW-1:0] diff_c [3];
	logic signed [DIFW-1:0] dface_c [3];
	logic [2:0]             lpos_c;
	logic signed [DIFW-1:0] diff_s4 [3];
	logic signed [DIFW-1:0] dface_s4 [3];
	logic [2:0]             lpos_s4;
	logic [RADW-1:0]        rad_s4;
	logic [2:0][3*RW-1:0]   ax_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hs_c[i] = LOCW'($signed({1'b0, half_s3[i]}));
			if (loc_s3[i] > hs_c[i]) begin
				cl_c[i] = hs_c[i];
			end else if (loc_s3[i] < -hs_c[i]) begin
				cl_c[i] = -hs_c[i];
			end else begin
				cl_c[i] = loc_s3[i];
			end
			diff_c[i]  = DIFW'(loc_s3[i]) - DIFW'(cl_c[i]);
			la_c[i]    = loc_s3[i][LOCW-1] ? -DIFW'(loc_s3[i]) : DIFW'(loc_s3[i]);
			dface_c[i] = DIFW'(hs_c[i]) - la_c[i];
			lpos_c[i]  = ~loc_s3[i][LOCW-1] && (loc_s3[i] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s4  <= diff_c;
			dface_s4 <= dface_c;
			lpos_s4  <= lpos_c;
			rad_s4   <= rad_s3;
			ax_s4    <= ax_s3;
		end
	end

	// stage 5: squares
	logic v_s5;
	logic signed [SQW-1:0]  sqp_c [3];
	logic signed [DIFW-1:0] dabs_c [3];
	logic [SQW-1:0]         sq_s5 [3];
	logic [R2W-1:0]         r2_s5;
	logic [2:0][MAGW-1:0]   mag_s5;
	logic [2:0]             dneg_s5;
	logic signed [DIFW-1:0] dface_s5 [3];
	logic [2:0]             lpos_s5;
	logic [RADW-1:0]        rad_s5;
	logic [2:0][3*RW-1:0]   ax_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sqp_c[i]  = SQW'(diff_s4[i]) * SQW'(diff_s4[i]);
			dabs_c[i] = diff_s4[i][DIFW-1] ? -diff_s4[i] : diff_s4[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i]   <= sqp_c[i];
				mag_s5[i]  <= dabs_c[i][MAGW-1:0];
				dneg_s5[i] <= diff_s4[i][DIFW-1];
			end
			r2_s5    <= R2W'(rad_s4) * R2W'(rad_s4);
			dface_s5 <= dface_s4;
			lpos_s5  <= lpos_s4;
			rad_s5   <= rad_s4;
			ax_s5    <= ax_s4;
		end
	end

	// stage 6: distance test, nearest face
	logic v_s6;
	logic [D2W-1:0]         d2_c;
	logic signed [DIFW-1:0] df_c;
	logic signed [DIFW-1:0] pin_c;
	side_t                  sb_c6;
	side_t                  sb_s6;
	logic [SQIN-1:0]        x_s6;

	always_comb begin
		d2_c = D2W'(sq_s5[0]) + D2W'(sq_s5[1]) + D2W'(sq_s5[2]);
		sb_c6        = '0;
		sb_c6.axis   = ax_s5;
		sb_c6.hit    = (d2_c <= D2W'(r2_s5));
		sb_c6.ctr_in = (d2_c == '0);
		sb_c6.rad    = rad_s5;
		sb_c6.mag    = mag_s5;
		sb_c6.dneg   = dneg_s5;
		if (dface_s5[0] <= dface_s5[1] && dface_s5[0] <= dface_s5[2]) begin
			sb_c6.face     = FACE_X;
			sb_c6.face_pos = lpos_s5[0];
			df_c           = dface_s5[0];
		end else if (dface_s5[1] <= dface_s5[0] && dface_s5[1] <= dface_s5[2]) begin
			sb_c6.face     = FACE_Y;
			sb_c6.face_pos = lpos_s5[1];
			df_c           = dface_s5[1];
		end else begin
			sb_c6.face     = FACE_Z;
			sb_c6.face_pos = lpos_s5[2];
			df_c           = dface_s5[2];
		end
		pin_c     = DIFW'({1'b0, rad_s5}) + df_c;
		sb_c6.pen = pin_c[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s6 <= sb_c6;
			x_s6  <= {d2_c[R2W-1:0], {SQSH{1'b0}}};
		end
	end

	// square root stages
	logic [RTW-1:0] root;
	logic           v_sq [1:SQN];
	side_t          sb_sq [1:SQN];

	soc_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.x    (x_s6),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sb_sq[1] <= sb_s6;
			for (int k = 2; k <= SQN; k++) begin
				sb_sq[k] <= sb_sq[k-1];
			end
		end
	end

	// stage 7: distance, penetration, divider operands
	logic v_s7;
	logic [RTW:0]          dsum_c;
	logic [CW-1:0]         dist_c;
	logic signed [CW:0]    pout_c;
	side_t                 sb_c7;
	side_t                 sb_s7;
	logic [NUMW-1:0]       num_s7 [3];
	logic [DENW-1:0]       den_s7;

	always_comb begin
		dsum_c = (RTW+1)'(root) + (RTW+1)'(1 << (SQSH/2 - 1));
		dist_c = dsum_c[RTW -: CW];
		pout_c = $signed((CW+1)'(sb_sq[SQN].rad)) - $signed({1'b0, dist_c});
		sb_c7  = sb_sq[SQN];
		if (!sb_sq[SQN].ctr_in) begin
			sb_c7.pen = pout_c[CW] ? '0 : pout_c[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s7 <= sb_c7;
			for (int i = 0; i < 3; i++) begin
				num_s7[i] <= NUMW'({sb_sq[SQN].mag[i], {(RF+9){1'b0}}}) + NUMW'(root);
			end
			den_s7 <= {root, 1'b0};
		end
	end

	// normal divider stages
	logic [QW-1:0] quo [3];
	logic          v_dv [1:DVN];
	side_t         sb_dv [1:DVN];

	for (genvar i = 0; i < 3; i++) begin : g_div
		soc_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s7[i]),
			.den (den_s7),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_dv[1] <= sb_s7;
			for (int k = 2; k <= DVN; k++) begin
				sb_dv[k] <= sb_dv[k-1];
			end
		end
	end

	// stage 8: local normal
	logic v_s8;
	logic [2:0]            fsel_c;
	logic signed [NLW-1:0] nl_c [3];
	logic signed [NLW-1:0] nl_s8 [3];
	side_t                 sb_s8;

	always_comb begin
		case (sb_dv[DVN].face)
			FACE_X:  fsel_c = 3'b001;
			FACE_Y:  fsel_c = 3'b010;
			FACE_Z:  fsel_c = 3'b100;
			default: fsel_c = 3'b000;
		endcase
		for (int i = 0; i < 3; i++) begin
			if (sb_dv[DVN].ctr_in) begin
				nl_c[i] = !fsel_c[i] ? '0 : (sb_dv[DVN].face_pos ? ONE : -ONE);
			end else begin
				nl_c[i] = sb_dv[DVN].dneg[i] ? -$signed({1'b0, quo[i]})
				                             : $signed({1'b0, quo[i]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s8 <= nl_c;
			sb_s8 <= sb_dv[DVN];
		end
	end

	// stage 9: rotate normal back to world
	logic v_s9;
	logic signed [WPW-1:0] wp_c [3][3];
	logic signed [WPW-1:0] wp_s9 [3][3];
	logic                  hit_s9, inside_s9;
	logic [CW-1:0]         pen_s9;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				wp_c[j][i] = WPW'($signed(sb_s8.axis[i][j*RW +: RW])) * WPW'(nl_s8[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wp_s9     <= wp_c;
			hit_s9    <= sb_s8.hit;
			inside_s9 <= sb_s8.ctr_in;
			pen_s9    <= sb_s8.pen;
		end
	end

	// stage 10: round, saturate, zero on miss
	logic v_s10;
	logic signed [WAW-1:0] wa_c [3];
	logic signed [WAW-1:0] wr_c [3];
	logic signed [WLW-1:0] wl_c [3];
	logic [3*RW-1:0]       nrm_c;
	contact_t              res_c;
	contact_t              res_s10;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			wa_c[j] = WAW'(wp_s9[j][0]) + WAW'(wp_s9[j][1]) + WAW'(wp_s9[j][2])
			        + WAW'(1 << (RF - 1));
			wr_c[j] = wa_c[j] >>> RF;
			wl_c[j] = wr_c[j][WLW-1:0];
			if (wl_c[j] > WMAX) begin
				nrm_c[j*RW +: RW] = WMAX[RW-1:0];
			end else if (wl_c[j] < WMIN) begin
				nrm_c[j*RW +: RW] = WMIN[RW-1:0];
			end else begin
				nrm_c[j*RW +: RW] = wl_c[j][RW-1:0];
			end
		end
		res_c = '0;
		if (hit_s9) begin
			res_c.hit               = 1'b1;
			res_c.center_inside     = inside_s9;
			res_c.contact_normal    = nrm_c;
			res_c.penetration_depth = pen_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s10 <= res_c;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			for (int k = 1; k <= SQN; k++) begin
				v_sq[k] <= 1'b0;
			end
			for (int k = 1; k <= DVN; k++) begin
				v_dv[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1  <= query_valid & live_q;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_sq[1] <= v_s6;
			for (int k = 2; k <= SQN; k++) begin
				v_sq[k] <= v_sq[k-1];
			end
			v_s7  <= v_sq[SQN];
			v_dv[1] <= v_s7;
			for (int k = 2; k <= DVN; k++) begin
				v_dv[k] <= v_dv[k-1];
			end
			v_s8  <= v_dv[DVN];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// output register and skid entry
	logic push, pop;

	assign push = v_s10 & en;
	assign pop  = out_v_q & contact_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_q <= res_s10;
			end else begin
				skid_q <= res_s10;
			end
		end
	end

	assign contact_valid = out_v_q;
	assign contact       = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry full while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !contact_ready))
		else $error("skid entry filled without a stalled output");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q.hit |-> out_q.contact_normal == '0
			&& out_q.penetration_depth == '0 && !out_q.center_inside)
		else $error("miss beat carries nonzero payload");

	a_inside_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.center_inside |-> out_q.hit)
		else $error("center inside without hit");

endmodule

// ===== hdl/soc_isqrt.sv =====
module soc_isqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [soc_pkg::SQIN-1:0]  x,
	output logic [soc_pkg::RTW-1:0]   root
);
	import soc_pkg::*;

	localparam int N    = RTW;
	localparam int REMW = RTW + 2;

	logic [SQIN-1:0] x_s   [1:N-1];
	logic [REMW-1:0] rem_s [1:N-1];
	logic [RTW-1:0]  rt_s  [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [SQIN-1:0] xi;
		logic [REMW-1:0] ri;
		logic [RTW-1:0]  ti;
		logic [REMW+1:0] part;
		logic [REMW+1:0] trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign xi = x;
			assign ri = '0;
			assign ti = '0;
		end else begin : g_next
			assign xi = x_s[k];
			assign ri = rem_s[k];
			assign ti = rt_s[k];
		end

		assign part  = {ri, xi[SQIN-1 -: 2]};
		assign trial = {2'b00, ti, 2'b01};
		assign ge    = (part >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k+1] <= {ti[RTW-2:0], ge};
			end
		end

		if (k < N - 1) begin : g_carry
			logic [REMW+1:0] diff;
			assign diff = part - trial;
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k+1]   <= xi << 2;
					rem_s[k+1] <= ge ? diff[REMW-1:0] : part[REMW-1:0];
				end
			end
		end
	end

	assign root = rt_s[N];

endmodule

// ===== hdl/soc_div.sv =====
module soc_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [soc_pkg::NUMW-1:0]  num,
	input  logic [soc_pkg::DENW-1:0]  den,
	output logic [soc_pkg::QW-1:0]    quo
);
	import soc_pkg::*;

	localparam int N    = QW;
	localparam int DRW  = DENW + 1;

	logic [DRW-1:0]  rem_s [1:N-1];
	logic [DENW-1:0] den_s [1:N-1];
	logic [QW-1:0]   lo_s  [1:N-1];
	logic [QW-1:0]   q_s   [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [DRW-1:0]  ri;
		logic [DENW-1:0] di;
		logic [QW-1:0]   li;
		logic [QW-1:0]   qi;
		logic [DRW:0]    part;
		logic [DRW:0]    dext;
		logic            ge;

		if (k == 0) begin : g_first
			assign ri = DRW'(num[NUMW-1:QW]);
			assign di = den;
			assign li = num[QW-1:0];
			assign qi = '0;
		end else begin : g_next
			assign ri = rem_s[k];
			assign di = den_s[k];
			assign li = lo_s[k];
			assign qi = q_s[k];
		end

		assign part = {ri, li[QW-1]};
		assign dext = (DRW+1)'(di);
		assign ge   = (part >= dext);

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1] <= {qi[QW-2:0], ge};
			end
		end

		if (k < N - 1) begin : g_carry
			logic [DRW:0] diff;
			assign diff = part - dext;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[DRW-1:0] : part[DRW-1:0];
					den_s[k+1] <= di;
					lo_s[k+1]  <= li << 1;
				end
			end
		end
	end

	assign quo = q_s[N];

endmodule

// ===== tb/sphere_obb_contact_checker.sv =====
module sphere_obb_contact_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	input  logic              query_ready,
	input  soc_pkg::query_t   query,
	input  logic              contact_valid,
	input  logic              contact_ready,
	input  soc_pkg::contact_t contact,
	output int                errors,
	output int                pending,
	output int                n_hits,
	output int                n_inside
);
	timeunit 1ns;
	timeprecision 1ps;
	import soc_pkg::*;

	localparam longint ONE_ROT = longint'(1) << RF;

	contact_t contacts_due[$];

	function automatic longint coord_lane(logic [3*CW-1:0] v, int k);
		logic signed [CW-1:0] s;
		s = v[k*CW +: CW];
		return longint'(s);
	endfunction

	function automatic longint rot_lane(logic [3*RW-1:0] v, int k);
		logic signed [RW-1:0] s;
		s = v[k*RW +: RW];
		return longint'(s);
	endfunction

	function automatic longint round_rot(longint acc);
		return (acc + (longint'(1) << (RF - 1))) >>> RF;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic contact_t predict_contact(query_t q);
		longint off[3], half[3], ax[3][3], loc[3], diff[3], nl[3];
		longint acc, c, pen, w, df, dd[3], rmax;
		longint unsigned dist2, r, d16, dist_q8, mag;
		int k;
		contact_t res;
		res = '0;
		dist2 = 0;
		rmax = (longint'(1) << (RW - 1)) - 1;
		for (int j = 0; j < 3; j++) begin
			off[j] = coord_lane(q.sphere_center, j) - coord_lane(q.box_center, j);
			half[j] = coord_lane(q.box_half_extents, j);
			if (half[j] < 0)
				half[j] = 0;
			ax[0][j] = rot_lane(q.box_axis_x, j);
			ax[1][j] = rot_lane(q.box_axis_y, j);
			ax[2][j] = rot_lane(q.box_axis_z, j);
			nl[j] = 0;
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += ax[i][j] * off[j];
			loc[i] = round_rot(acc);
			c = loc[i];
			if (c < -half[i])
				c = -half[i];
			if (c > half[i])
				c = half[i];
			diff[i] = loc[i] - c;
			dist2 += longint'(diff[i] * diff[i]);
		end
		r = q.sphere_radius;
		if (dist2 > r * r)
			return res;
		res.hit = 1'b1;
		res.center_inside = (dist2 == 0);
		if (dist2 == 0) begin
			for (int i = 0; i < 3; i++)
				dd[i] = half[i] - (loc[i] < 0 ? -loc[i] : loc[i]);
			if (dd[0] <= dd[1] && dd[0] <= dd[2])
				k = 0;
			else if (dd[1] <= dd[0] && dd[1] <= dd[2])
				k = 1;
			else
				k = 2;
			df = dd[k];
			nl[k] = loc[k] > 0 ? ONE_ROT : -ONE_ROT;
			pen = longint'(r) + df;
		end else begin
			d16 = int_sqrt(dist2 << 16);
			dist_q8 = (d16 + 128) >> 8;
			pen = longint'(r) - longint'(dist_q8);
			for (int i = 0; i < 3; i++) begin
				mag = longint'(diff[i] < 0 ? -diff[i] : diff[i]) << (RF + 8);
				w = longint'((2 * mag + d16) / (2 * d16));
				nl[i] = diff[i] < 0 ? -w : w;
			end
		end
		if (pen < 0)
			pen = 0;
		if (pen > (longint'(1) << CW) - 1)
			pen = (longint'(1) << CW) - 1;
		res.penetration_depth = pen[CW-1:0];
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc += ax[i][j] * nl[i];
			w = round_rot(acc);
			if (w > rmax)
				w = rmax;
			if (w < -rmax - 1)
				w = -rmax - 1;
			res.contact_normal[j*RW +: RW] = w[RW-1:0];
		end
		return res;
	endfunction

	assign pending = contacts_due.size();

	always @(posedge clk or negedge arst_n) begin
		contact_t want;
		if (!arst_n) begin
			errors <= 0;
			n_hits <= 0;
			n_inside <= 0;
		end else begin
			if (query_valid && query_ready)
				contacts_due = {contacts_due, predict_contact(query)};
			if (contact_valid && contact_ready) begin
				if (contacts_due.size() == 0) begin
					$display("%t: contact beat with nothing expected: %h", $realtime, contact);
					errors <= errors + 1;
				end else begin
					want = contacts_due.pop_front();
					n_hits <= n_hits + want.hit;
					n_inside <= n_inside + want.center_inside;
					if (want.hit !== contact.hit
					    || want.center_inside !== contact.center_inside
					    || want.contact_normal !== contact.contact_normal
					    || want.penetration_depth !== contact.penetration_depth) begin
						$display("%t: mismatch expected hit=%b in=%b n=%h pen=%h",
						         $realtime, want.hit, want.center_inside,
						         want.contact_normal, want.penetration_depth);
						$display("%t:          actual   hit=%b in=%b n=%h pen=%h",
						         $realtime, contact.hit, contact.center_inside,
						         contact.contact_normal, contact.penetration_depth);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/tb_sphere_obb_contact_core.sv =====
module tb_sphere_obb_contact_core;
	timeunit 1ns;
	timeprecision 1ps;
	import soc_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam longint ONE = 16384;
	localparam longint DIAG = 11585;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     query_valid = 1'b0;
	logic     query_ready;
	query_t   query = '0;
	logic     contact_valid;
	logic     contact_ready = 1'b0;
	contact_t contact;

	int errors, pending, n_hits, n_inside;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int quiet_cycles = 0, n_sent = 0;

	sphere_obb_contact_core i_dut (.*);

	sphere_obb_contact_checker i_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk)
		contact_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if ((query_valid && query_ready) || (contact_valid && contact_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d contacts pending",
			         STALL_LIMIT, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [3*CW-1:0] coords(longint x, longint y, longint z);
		return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
	endfunction

	function automatic logic [3*RW-1:0] rots(longint x, longint y, longint z);
		return {z[RW-1:0], y[RW-1:0], x[RW-1:0]};
	endfunction

	function automatic query_t box_query(longint sx, longint sy, longint sz, longint r,
	                                     longint hx, longint hy, longint hz);
		query_t q;
		q = '0;
		q.sphere_center = coords(sx, sy, sz);
		q.sphere_radius = r[RADW-1:0];
		q.box_center = coords(0, 0, 0);
		q.box_half_extents = coords(hx, hy, hz);
		q.box_axis_x = rots(ONE, 0, 0);
		q.box_axis_y = rots(0, ONE, 0);
		q.box_axis_z = rots(0, 0, ONE);
		return q;
	endfunction

	function automatic longint srand(longint mag);
		return longint'($urandom_range(32'(2 * mag))) - mag;
	endfunction

	function automatic query_t random_query();
		query_t q;
		longint h[3], c[3], r, v;
		int pick;
		if ($urandom_range(99) < 15) begin
			for (int b = 0; b < $bits(query_t); b++)
				q[b] = 1'($urandom_range(1));
			if ($urandom_range(1))
				q.sphere_radius[RADW-1] = 1'b1;
			return q;
		end
		r = $urandom_range($urandom_range(1) ? 2000 : (1 << RADW) - 1);
		for (int j = 0; j < 3; j++) begin
			h[j] = $urandom_range($urandom_range(1) ? 3000 : (1 << HW) - 1);
			c[j] = srand(1 << (CW - 2));
		end
		q.sphere_radius = r[RADW-1:0];
		q.box_center = coords(c[0], c[1], c[2]);
		q.box_half_extents = coords(h[0], h[1], h[2]);
		q.sphere_center = coords(c[0] + srand(h[0] + r + 8), c[1] + srand(h[1] + r + 8),
		                         c[2] + srand(h[2] + r + 8));
		pick = $urandom_range(5);
		v = $urandom_range(1) ? ONE : -ONE;
		case (pick)
			0: begin
				q.box_axis_x = rots(v, 0, 0);
				q.box_axis_y = rots(0, ONE, 0);
				q.box_axis_z = rots(0, 0, v);
			end
			1: begin
				q.box_axis_x = rots(0, v, 0);
				q.box_axis_y = rots(0, 0, ONE);
				q.box_axis_z = rots(v, 0, 0);
			end
			2: begin
				q.box_axis_x = rots(DIAG, DIAG, 0);
				q.box_axis_y = rots(-DIAG, DIAG, 0);
				q.box_axis_z = rots(0, 0, v);
			end
			3: begin
				q.box_axis_x = rots(DIAG, 0, -DIAG);
				q.box_axis_y = rots(0, v, 0);
				q.box_axis_z = rots(DIAG, 0, DIAG);
			end
			default: begin
				q.box_axis_x = rots(srand(32767), srand(32767), srand(32767));
				q.box_axis_y = rots(srand(32767), srand(32767), srand(32767));
				q.box_axis_z = rots(srand(32767), srand(32767), srand(32767));
			end
		endcase
		return q;
	endfunction

	task automatic send_query(query_t q);
		query_valid <= 1'b1;
		query <= q;
		@(posedge clk);
		while (!query_ready)
			@(posedge clk);
		n_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			query_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic drain();
		query_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		query_t q;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 10;
		recv_stall_pct = 57;
		// inside with x/y/z ties, zero components, face on each axis
		send_query(box_query(0, 0, 0, 256, 512, 512, 512));
		send_query(box_query(0, 100, 0, 256, 512, 512, 512));
		send_query(box_query(0, 0, -100, 256, 512, 512, 512));
		send_query(box_query(100, 0, 0, 256, 512, 512, 512));
		send_query(box_query(-100, 0, 0, 256, 512, 512, 512));
		send_query(box_query(10, 20, 30, 256, 600, 300, 900));
		// outside: face, corner, tangent, just missing, miss
		send_query(box_query(700, 0, 0, 256, 512, 512, 512));
		send_query(box_query(700, 700, 700, 512, 512, 512, 512));
		send_query(box_query(768, 0, 0, 256, 512, 512, 512));
		send_query(box_query(769, 0, 0, 256, 512, 512, 512));
		send_query(box_query(0, -5000, 0, 256, 512, 512, 512));
		// negative half extents read as zero, zero radius
		send_query(box_query(0, 0, 0, 0, -1, -512, 512));
		send_query(box_query(300, 0, 0, 512, -300, -1, -1));
		send_query(box_query(0, 0, 0, 0, 0, 0, 0));
		// field extremes
		send_query(box_query(-(1 << (CW - 1)), (1 << (CW - 1)) - 1, 0, (1 << RADW) - 1,
		                     (1 << HW) - 1, 0, 0));
		send_query(box_query((1 << (CW - 1)) - 1, (1 << (CW - 1)) - 1, (1 << (CW - 1)) - 1,
		                     (1 << RADW) - 1, (1 << HW) - 1, (1 << HW) - 1, (1 << HW) - 1));
		q = box_query(1000, -1000, 500, (1 << RADW) - 1, 100, 100, 100);
		q.box_axis_x = rots(32767, 32767, -32768);
		q.box_axis_y = rots(32767, -32768, 32767);
		q.box_axis_z = rots(-32768, 32767, 32767);
		send_query(q);
		q.sphere_center = coords(0, 0, 0);
		send_query(q);
		send_query('0);
		send_query('1);
		drain();

		for (int i = 0; i < 500; i++) begin
			if (i == 170) begin
				send_idle_pct = 57;
				recv_stall_pct = 10;
			end else if (i == 340) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			send_query(random_query());
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d queries: %0d hits, %0d with the center inside the box",
		         n_sent, n_hits, n_inside);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
